// File: hw/rtl/pnsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsr_pkg
// Shared types and constants of the packed nibble sprite renderer.
// ----------------------------------------------------------------------------
package pnsr_pkg;

    localparam int ROM_DEPTH     = 32768;
    localparam int SPRITE_COUNT  = 32;
    localparam int MAX_ROW_BYTES = 128;
    localparam int SCREEN_SIZE   = 256;

    localparam int ROM_AW  = $clog2(ROM_DEPTH);
    localparam int DESC_AW = $clog2(SPRITE_COUNT * 16);
    localparam int SPR_W   = 6;

    typedef enum logic [1:0] {
        OP_LOAD_GFX  = 2'd0,
        OP_LOAD_DESC = 2'd1,
        OP_START     = 2'd2,
        OP_STEP      = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_FLIP   = 3'd0;
    localparam logic [2:0] REG_SUPER  = 3'd1;
    localparam logic [2:0] REG_LEFT   = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;
    localparam logic [2:0] REG_BOTTOM = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAIT,
        ST_DESC_RD,
        ST_DESC_EVAL,
        ST_ROW_RD,
        ST_ROW_EVAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DESC = 2'd1,
        PH_ROW  = 2'd2
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_mem;    // perform a load opcode
        logic start;        // reset sprite index to zero
        logic desc_read;    // issue descriptor byte read
        logic desc_eval;    // evaluate the fetched descriptor
        logic row_eval;     // evaluate the fetched byte
        logic clear_out;    // zero the result register, frame_done set if idle
    } cmd_t;

    typedef struct packed {
        logic       desc_done;  // all descriptor bytes fetched
        phase_t     phase;
    } status_t;

    typedef struct packed {
        logic       first_valid;
        logic [7:0] first_x;
        logic [9:0] first_pen;
        logic       second_valid;
        logic [7:0] second_x;
        logic [9:0] second_pen;
        logic [7:0] pixel_y;
        logic       frame_done;
    } result_t;

endpackage

// File: hw/rtl/pnsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsr_in_if / pnsr_out_if
// Valid/ready request and result channels of the sprite renderer.
// ----------------------------------------------------------------------------
interface pnsr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [14:0] address;
    logic [7:0]  data;
    modport source (output valid, opcode, address, data, input ready);
    modport sink   (input valid, opcode, address, data, output ready);
endinterface

interface pnsr_out_if;
    logic        valid;
    logic        ready;
    logic        first_valid;
    logic [7:0]  first_x;
    logic [9:0]  first_pen;
    logic        second_valid;
    logic [7:0]  second_x;
    logic [9:0]  second_pen;
    logic [7:0]  pixel_y;
    logic        frame_done;
    modport source (output valid, first_valid, first_x, first_pen, second_valid, second_x,
                    second_pen, pixel_y, frame_done, input ready);
    modport sink   (input valid, first_valid, first_x, first_pen, second_valid, second_x,
                    second_pen, pixel_y, frame_done, output ready);
endinterface

// File: hw/rtl/pnsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsr_datapath
// Memories, sprite registers and pixel evaluation of the sprite renderer.
// ----------------------------------------------------------------------------
module pnsr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pnsr_pkg::cmd_t        cmd,
    output pnsr_pkg::status_t     status,
    input  logic [1:0]            op,
    input  logic [14:0]           address,
    input  logic [7:0]            data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    output pnsr_pkg::result_t     result
);
    import pnsr_pkg::*;

    logic [7:0] rom [ROM_DEPTH];
    logic [7:0] desc [SPRITE_COUNT*16];
    logic [7:0] rom_q_reg;
    logic [7:0] desc_q_reg;

    logic flip_cfg_reg, super_cfg_reg;
    logic [7:0] left_reg, right_reg, top_reg, bottom_reg;

    phase_t      phase_reg;
    logic [SPR_W-1:0] sprite_reg;
    logic [7:0]  row_counter_reg, row_total_reg, bytes_reg;
    logic [15:0] offset_reg, skip_reg;
    logic [14:0] ptr_reg;
    logic [8:0]  column_reg;
    logic [9:0]  row_y_reg;
    logic [7:0]  lat_x_reg;
    logic [9:0]  lat_pen_reg;
    logic        lat_flip_reg;
    logic [2:0]  dcnt_reg;      // descriptor byte being read
    logic [2:0]  dstore_reg;    // descriptor byte arriving
    logic        dvalid_reg;
    logic [7:0]  d_reg [8];
    result_t     result_reg;

    logic [DESC_AW-1:0] desc_addr;
    assign desc_addr = DESC_AW'({sprite_reg, 4'b0} + {{(DESC_AW-3){1'b0}}, dcnt_reg});
    assign status.desc_done = dvalid_reg && dstore_reg == 3'd7;
    assign status.phase = phase_reg;
    assign result = result_reg;

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.write_mem && op == OP_LOAD_GFX)
        begin
            rom[address[ROM_AW-1:0]] <= data;
        end
        if (cmd.write_mem && op == OP_LOAD_DESC)
        begin
            desc[address[DESC_AW-1:0]] <= data;
        end
        rom_q_reg <= rom[ptr_reg[ROM_AW-1:0]];
        desc_q_reg <= desc[desc_addr];
        if (dvalid_reg)
        begin
            d_reg[dstore_reg] <= desc_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_cfg_reg  <= 1'b0;
            super_cfg_reg <= 1'b0;
            left_reg      <= 8'd8;
            right_reg     <= 8'd247;
            top_reg       <= 8'd0;
            bottom_reg    <= 8'd223;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLIP:   flip_cfg_reg  <= cfg_data[0];
                REG_SUPER:  super_cfg_reg <= cfg_data[0];
                REG_LEFT:   left_reg      <= cfg_data;
                REG_RIGHT:  right_reg     <= cfg_data;
                REG_TOP:    top_reg       <= cfg_data;
                REG_BOTTOM: bottom_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pixel evaluation.
    logic [3:0] c1, c2;
    logic [8:0] x1_raw, x2_raw;
    logic [9:0] x1s, x2s, ys;
    logic vis1, vis2, row_end, last_row, last_sprite, skip_sprite;
    logic [15:0] new_offset;
    logic [8:0] height;
    logic [SPR_W:0] sprite_inc;
    result_t res_next;
    result_t clear_val;

    function automatic logic visible(input logic [9:0] x, input logic [9:0] y,
                                     input logic [7:0] l, input logic [7:0] r,
                                     input logic [7:0] t, input logic [7:0] b);
        logic in_screen;
        in_screen = x < 10'(SCREEN_SIZE) && y < 10'(SCREEN_SIZE);
        return in_screen && x >= {2'b0, l} && x <= {2'b0, r}
               && y >= {2'b0, t} && y <= {2'b0, b};
    endfunction

    always_comb
    begin
        c1 = offset_reg[15] ? rom_q_reg[3:0] : rom_q_reg[7:4];
        c2 = offset_reg[15] ? rom_q_reg[7:4] : rom_q_reg[3:0];
        x1_raw = {1'b0, lat_x_reg} + column_reg;
        x2_raw = x1_raw + 9'd1;
        // Signed 10-bit view; under flip, values past the screen go negative.
        if (lat_flip_reg)
        begin
            x1s = 10'(SCREEN_SIZE - 1) - {1'b0, x1_raw};
            x2s = 10'(SCREEN_SIZE - 1) - {1'b0, x2_raw};
            ys  = 10'(SCREEN_SIZE - 1) - row_y_reg;
        end
        else
        begin
            x1s = {1'b0, x1_raw};
            x2s = {1'b0, x2_raw};
            ys  = row_y_reg;
        end
        vis1 = visible(x1s, ys, left_reg, right_reg, top_reg, bottom_reg);
        vis2 = visible(x2s, ys, left_reg, right_reg, top_reg, bottom_reg);
        row_end = c1 == 4'hf || c2 == 4'hf || (bytes_reg + 8'd1) >= 8'(MAX_ROW_BYTES);
        last_row = (row_counter_reg + 8'd1) >= row_total_reg;
        sprite_inc = {1'b0, sprite_reg} + 1'b1;
        last_sprite = sprite_inc >= (SPR_W+1)'(SPRITE_COUNT);
        new_offset = {d_reg[7], d_reg[6]} + {d_reg[5], d_reg[4]};
        height = {1'b0, d_reg[1]} - {1'b0, d_reg[0]};
        skip_sprite = d_reg[2] == 8'hff || height[8] || height == 9'd0;
        res_next = '0;
        res_next.pixel_y = ys[7:0];
        if (c1 != 4'hf && c1 != 4'h0 && vis1)
        begin
            res_next.first_valid = 1'b1;
            res_next.first_x = x1s[7:0];
            res_next.first_pen = lat_pen_reg + {6'b0, c1};
        end
        if (c1 != 4'hf && c2 != 4'hf && c2 != 4'h0 && vis2)
        begin
            res_next.second_valid = 1'b1;
            res_next.second_x = x2s[7:0];
            res_next.second_pen = lat_pen_reg + {6'b0, c2};
        end
        // A row step that ends the last row of the last sprite ends the frame.
        res_next.frame_done = row_end && last_row && last_sprite;
        clear_val = '0;
        clear_val.frame_done = phase_reg == PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sprite_reg <= '0;
            row_counter_reg <= '0;
            row_total_reg <= '0;
            bytes_reg <= '0;
            offset_reg <= '0;
            skip_reg <= '0;
            ptr_reg <= '0;
            column_reg <= '0;
            row_y_reg <= '0;
            lat_x_reg <= '0;
            lat_pen_reg <= '0;
            lat_flip_reg <= 1'b0;
            dcnt_reg <= '0;
            dstore_reg <= '0;
            dvalid_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            dvalid_reg <= cmd.desc_read;
            dstore_reg <= dcnt_reg;
            if (cmd.desc_read)
            begin
                dcnt_reg <= dcnt_reg + 3'd1;
            end
            else if (cmd.start || cmd.desc_eval)
            begin
                dcnt_reg <= '0;
            end
            if (cmd.clear_out)
            begin
                result_reg <= clear_val;
            end
            else if (cmd.row_eval)
            begin
                result_reg <= res_next;
            end
            if (cmd.start)
            begin
                sprite_reg <= '0;
                phase_reg <= PH_DESC;
            end
            else if (cmd.desc_eval)
            begin
                if (skip_sprite)
                begin
                    if (last_sprite)
                    begin
                        phase_reg <= PH_IDLE;
                        sprite_reg <= '0;
                    end
                    else
                    begin
                        sprite_reg <= sprite_inc[SPR_W-1:0];
                        phase_reg <= PH_DESC;
                    end
                end
                else
                begin
                    lat_x_reg <= d_reg[2];
                    lat_pen_reg <= 10'h100 + {4'b0, d_reg[3][1:0], 4'b0}
                                   + (super_cfg_reg ? 10'h100 : 10'h0);
                    skip_reg <= {d_reg[5], d_reg[4]};
                    lat_flip_reg <= flip_cfg_reg;
                    row_total_reg <= height[7:0];
                    row_counter_reg <= '0;
                    row_y_reg <= flip_cfg_reg ? {2'b0, d_reg[1]} : {2'b0, d_reg[0]} + 10'd1;
                    offset_reg <= new_offset;
                    ptr_reg <= new_offset[14:0];
                    column_reg <= '0;
                    bytes_reg <= '0;
                    phase_reg <= PH_ROW;
                end
            end
            else if (cmd.row_eval)
            begin
                if (row_end)
                begin
                    row_counter_reg <= row_counter_reg + 8'd1;
                    row_y_reg <= lat_flip_reg ? row_y_reg - 10'd1 : row_y_reg + 10'd1;
                end
                if (row_end && !last_row)
                begin
                    offset_reg <= offset_reg + skip_reg;
                    ptr_reg <= 15'(offset_reg + skip_reg);
                    column_reg <= '0;
                    bytes_reg <= '0;
                end
                else
                begin
                    ptr_reg <= offset_reg[15] ? ptr_reg - 15'd1 : ptr_reg + 15'd1;
                    column_reg <= column_reg + 9'd2;
                    bytes_reg <= bytes_reg + 8'd1;
                end
                if (row_end && last_row)
                begin
                    if (last_sprite)
                    begin
                        phase_reg <= PH_IDLE;
                        sprite_reg <= '0;
                    end
                    else
                    begin
                        sprite_reg <= sprite_inc[SPR_W-1:0];
                        phase_reg <= PH_DESC;
                    end
                end
            end
        end
    end

endmodule

// File: hw/rtl/pnsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsr_ctrl
// Request sequencer of the sprite renderer.
// ----------------------------------------------------------------------------
module pnsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pnsr_pkg::cmd_t        cmd,
    input  pnsr_pkg::status_t     status
);
    import pnsr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every request ends in ST_OUT; the result is cleared on acceptance and the
    // frame_done flag there is taken from the phase after the action.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clear_out = 1'b1;
                    unique case (opcode_t'(op)) inside
                        OP_LOAD_GFX, OP_LOAD_DESC:
                        begin
                            cmd.write_mem = 1'b1;
                            state_next = ST_WAIT;
                        end
                        OP_START:
                        begin
                            cmd.start = 1'b1;
                            state_next = ST_WAIT;
                        end
                        default:
                        begin
                            if (status.phase == PH_DESC)
                            begin
                                cmd.desc_read = 1'b1;
                                state_next = ST_DESC_RD;
                            end
                            else if (status.phase == PH_ROW)
                            begin
                                state_next = ST_ROW_RD;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                cmd.clear_out = 1'b1;
                state_next = ST_OUT;
            end
            ST_DESC_RD:
            begin
                if (status.desc_done)
                begin
                    state_next = ST_DESC_EVAL;
                end
                else
                begin
                    cmd.desc_read = 1'b1;
                end
            end
            ST_DESC_EVAL:
            begin
                cmd.desc_eval = 1'b1;
                state_next = ST_WAIT;
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_EVAL;
            end
            ST_ROW_EVAL:
            begin
                cmd.row_eval = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_ready) |=> state_reg == ST_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_eval |=> state_reg == ST_OUT)
        else $error("row evaluation not followed by output");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while result pending");

endmodule

// File: hw/rtl/packed_nibble_sprite_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_nibble_sprite_renderer
// Sprite engine that expands packed 4-bit sprite rows into pen writes.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: load a graphics byte, load a descriptor byte,
// start a frame or step the engine. Each accepted request gives exactly one
// result on out_ch, carrying up to two pen writes and the frame_done flag.
// One request is handled at a time. Loads, start and idle steps go through a
// wait state to the result; a row step reads the graphics ROM, then evaluates;
// a descriptor step reads the eight descriptor bytes one by one through the
// single descriptor RAM read port, then evaluates them.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect
// at once; the user must make them while the engine is idle (not enforced).
// Reset clears the sequencer and the sprite state and loads the clip window
// defaults; graphics and descriptor memories keep their contents.
// When the receiver holds out_ch.ready low the result is held and no new
// request is accepted.
// ----------------------------------------------------------------------------
module packed_nibble_sprite_renderer (
    input  logic        clk,
    input  logic        rst_n,
    pnsr_in_if.sink     in_ch,
    pnsr_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pnsr_pkg::*;

    cmd_t    cmd;
    status_t status;
    result_t result;

    pnsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .op        (in_ch.opcode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    pnsr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (in_ch.opcode),
        .address   (in_ch.address),
        .data      (in_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    assign out_ch.first_valid  = result.first_valid;
    assign out_ch.first_x      = result.first_x;
    assign out_ch.first_pen    = result.first_pen;
    assign out_ch.second_valid = result.second_valid;
    assign out_ch.second_x     = result.second_x;
    assign out_ch.second_pen   = result.second_pen;
    assign out_ch.pixel_y      = result.pixel_y;
    assign out_ch.frame_done   = result.frame_done;

endmodule

// File: verif/pnsr_render_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsr_render_checker
// Watches the request, result and register ports of the sprite renderer. It
// keeps its own copy of the graphics and descriptor memories and of the
// sprite walk, predicts the pen writes of every accepted request and compares
// them in order with the results that the block hands out.
// ----------------------------------------------------------------------------
module pnsr_render_checker (
    input  logic       clk,
    input  logic       rst_n,
    pnsr_in_if         in_ch,
    pnsr_out_if        out_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fails,
    output int         pending
);
    import pnsr_pkg::*;

    localparam logic [3:0] NIB_CLEAR = 4'h0;
    localparam logic [3:0] NIB_END   = 4'hF;

    logic [7:0] gfx_mem [ROM_DEPTH];
    logic [7:0] desc_mem [SPRITE_COUNT * 16];

    logic       flip_reg, super_reg;
    logic [7:0] left_reg, right_reg, top_reg, bottom_reg;

    phase_t      ph;
    int          spr_idx, row_cnt, row_tot, bytes_in_row;
    logic [15:0] row_off, lat_skip;
    logic [14:0] ptr;
    logic [8:0]  col;
    logic [9:0]  row_y, lat_pen;
    int          lat_x;
    logic        lat_flip;

    result_t     pen_writes_q [$];

    function automatic void advance_sprite();
        if (spr_idx + 1 >= SPRITE_COUNT) begin
            ph = PH_IDLE;
            spr_idx = 0;
        end
        else begin
            spr_idx++;
            ph = PH_DESC;
        end
    endfunction

    function automatic void start_row();
        row_off = row_off + lat_skip;
        ptr = row_off[14:0];
        col = '0;
        bytes_in_row = 0;
    endfunction

    function automatic bit on_screen(int x, int y);
        if (x < 0 || y < 0 || x >= SCREEN_SIZE || y >= SCREEN_SIZE)
            return 0;
        return x >= left_reg && x <= right_reg && y >= top_reg && y <= bottom_reg;
    endfunction

    function automatic result_t render_request(opcode_t op, logic [14:0] addr, logic [7:0] data);
        result_t    r;
        int         b, height, x1, x2, y;
        logic [7:0] rd, top, bot;
        logic [3:0] c1, c2;
        r = '0;
        case (op)
            OP_LOAD_GFX:  gfx_mem[addr % ROM_DEPTH] = data;
            OP_LOAD_DESC: desc_mem[addr % (SPRITE_COUNT * 16)] = data;
            OP_START:
            begin
                spr_idx = 0;
                ph = PH_DESC;
            end
            default:
            begin
                if (ph == PH_DESC) begin
                    b = spr_idx * 16;
                    top = desc_mem[b];
                    bot = desc_mem[b + 1];
                    height = int'(bot) - int'(top);
                    if (desc_mem[b + 2] == 8'hFF || height <= 0) begin
                        advance_sprite();
                    end
                    else begin
                        lat_x = desc_mem[b + 2];
                        lat_pen = 10'h100 + 10'h10 * desc_mem[b + 3][1:0]
                                  + (super_reg ? 10'h100 : 10'h000);
                        lat_skip = {desc_mem[b + 5], desc_mem[b + 4]};
                        row_off = {desc_mem[b + 7], desc_mem[b + 6]};
                        lat_flip = flip_reg;
                        row_tot = height;
                        row_cnt = 0;
                        row_y = lat_flip ? {2'b00, bot} : {2'b00, top} + 10'd1;
                        start_row();
                        ph = PH_ROW;
                    end
                end
                else if (ph == PH_ROW) begin
                    rd = gfx_mem[ptr];
                    // A backward row reads the low nibble first.
                    if (row_off[15]) begin
                        c1 = rd[3:0];
                        c2 = rd[7:4];
                        ptr = ptr - 15'd1;
                    end
                    else begin
                        c1 = rd[7:4];
                        c2 = rd[3:0];
                        ptr = ptr + 15'd1;
                    end
                    x1 = lat_x + col;
                    x2 = x1 + 1;
                    y = row_y;
                    if (lat_flip) begin
                        x1 = SCREEN_SIZE - 1 - x1;
                        x2 = SCREEN_SIZE - 1 - x2;
                        y = SCREEN_SIZE - 1 - y;
                    end
                    r.pixel_y = y[7:0];
                    if (c1 != NIB_END && c1 != NIB_CLEAR && on_screen(x1, y)) begin
                        r.first_valid = 1'b1;
                        r.first_x = x1[7:0];
                        r.first_pen = lat_pen + c1;
                    end
                    if (c1 != NIB_END && c2 != NIB_END && c2 != NIB_CLEAR && on_screen(x2, y))
                    begin
                        r.second_valid = 1'b1;
                        r.second_x = x2[7:0];
                        r.second_pen = lat_pen + c2;
                    end
                    col = col + 9'd2;
                    bytes_in_row++;
                    if (c1 == NIB_END || c2 == NIB_END || bytes_in_row >= MAX_ROW_BYTES) begin
                        row_cnt++;
                        row_y = lat_flip ? row_y - 10'd1 : row_y + 10'd1;
                        if (row_cnt >= row_tot)
                            advance_sprite();
                        else
                            start_row();
                    end
                end
            end
        endcase
        r.frame_done = (ph == PH_IDLE);
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            flip_reg = 1'b0;
            super_reg = 1'b0;
            left_reg = 8'd8;
            right_reg = 8'd247;
            top_reg = 8'd0;
            bottom_reg = 8'd223;
            ph = PH_IDLE;
            spr_idx = 0;
            row_cnt = 0;
            row_tot = 0;
            bytes_in_row = 0;
            row_off = '0;
            lat_skip = '0;
            ptr = '0;
            col = '0;
            row_y = '0;
            lat_pen = '0;
            lat_x = 0;
            lat_flip = 1'b0;
            pen_writes_q.delete();
            fails = 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FLIP:   flip_reg = cfg_data[0];
                    REG_SUPER:  super_reg = cfg_data[0];
                    REG_LEFT:   left_reg = cfg_data;
                    REG_RIGHT:  right_reg = cfg_data;
                    REG_TOP:    top_reg = cfg_data;
                    REG_BOTTOM: bottom_reg = cfg_data;
                    default:    ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                pen_writes_q.push_back(render_request(opcode_t'(in_ch.opcode), in_ch.address,
                                                      in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (pen_writes_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end
                else begin
                    want = pen_writes_q.pop_front();
                    compare_field("first_valid", want.first_valid, out_ch.first_valid);
                    compare_field("first_x", want.first_x, out_ch.first_x);
                    compare_field("first_pen", want.first_pen, out_ch.first_pen);
                    compare_field("second_valid", want.second_valid, out_ch.second_valid);
                    compare_field("second_x", want.second_x, out_ch.second_x);
                    compare_field("second_pen", want.second_pen, out_ch.second_pen);
                    compare_field("pixel_y", want.pixel_y, out_ch.pixel_y);
                    compare_field("frame_done", want.frame_done, out_ch.frame_done);
                end
            end
            pending <= pen_writes_q.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level test of the sprite renderer. Loads graphics and descriptors,
// runs frames under several flip, palette and clip settings with random
// sprites, mid-frame loads and restarts, and random request gaps and result
// stalls. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pnsr_pkg::*;

    localparam int          ITEM_TARGET = 1350;
    localparam int          QUIET_AFTER = 1150;
    localparam int          DRAIN_WAIT  = 20;
    localparam logic [14:0] GFX_LO      = 15'h0F8;
    localparam logic [14:0] GFX_HI      = 15'h207;
    localparam logic [14:0] RUN_BASE    = 15'h400;
    localparam logic [2:0]  REG_UNUSED  = 3'd6;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int         fails, pending;
    int         items;
    int         stall_left;
    bit         quiet;
    logic       last_done;

    pnsr_in_if  in_ch ();
    pnsr_out_if out_ch ();

    packed_nibble_sprite_renderer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pnsr_render_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts, none once the run has gone quiet.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            last_done <= 1'b1;
        end
        else begin
            if (out_ch.valid && out_ch.ready)
                last_done <= out_ch.frame_done;
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(opcode_t op, logic [14:0] addr, logic [7:0] data);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.address <= addr;
        in_ch.data <= data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items++;
        if (items >= QUIET_AFTER)
            quiet = 1'b1;
    endtask

    task automatic await_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Every byte on an 8-aligned address holds an end nibble, so any row
    // started inside the graphics window ends within eight bytes.
    function automatic logic [7:0] gfx_byte(logic [14:0] addr);
        logic [7:0] v;
        v = 8'($urandom);
        if (addr[2:0] == 3'd0) begin
            if ($urandom_range(0, 1))
                v[7:4] = 4'hF;
            else
                v[3:0] = 4'hF;
        end
        return v;
    endfunction

    task automatic load_sprite(int s, logic [7:0] top, logic [7:0] bot, logic [7:0] x,
                               logic [15:0] skip, logic [15:0] offs);
        logic [7:0] bytes [8];
        bytes = '{top, bot, x, 8'($urandom), skip[7:0], skip[15:8], offs[7:0], offs[15:8]};
        for (int k = 0; k < 8; k++)
            send_request(OP_LOAD_DESC, {6'($urandom), 5'(s), 4'(k)}, bytes[k]);
    endtask

    task automatic random_sprite(int s);
        int         kind, h;
        logic [7:0] top, x;
        logic [15:0] skip, offs;
        kind = $urandom_range(0, 9);
        h = $urandom_range(1, 4);
        top = 8'($urandom_range(0, 255 - h));
        case ($urandom_range(0, 5))
            0:       x = 8'd0;
            1:       x = 8'd254;
            default: x = 8'($urandom_range(0, 254));
        endcase
        skip = 16'($signed($urandom_range(0, 16)) - 8);
        offs = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 15'($urandom_range(16'h128, 16'h1D8))};
        if (kind == 0)
            load_sprite(s, top, top + 8'(h), 8'hFF, skip, offs);
        else if (kind == 1)
            load_sprite(s, top, top - 8'($urandom_range(0, 3)), x, skip, offs);
        else
            load_sprite(s, top, top + 8'(h), x, skip, offs);
        // Bytes past the descriptor fields are never read.
        if ($urandom_range(0, 3) == 0)
            send_request(OP_LOAD_DESC, {6'($urandom), 5'(s), 4'($urandom_range(8, 15))},
                         8'($urandom));
    endtask

    task automatic write_config(logic flip, logic sup, logic [7:0] l, logic [7:0] r,
                                logic [7:0] t, logic [7:0] b);
        logic [2:0] idx [7];
        logic [7:0] val [7];
        idx = '{REG_FLIP, REG_SUPER, REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM, REG_UNUSED};
        val = '{{7'($urandom), flip}, {7'($urandom), sup}, l, r, t, b, 8'($urandom)};
        await_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        for (int k = 0; k < 7; k++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_frame();
        int steps, pick;
        send_request(OP_START, 15'($urandom), 8'($urandom));
        await_results();
        steps = 0;
        while (!last_done && steps < 2000 && items < ITEM_TARGET) begin
            pick = $urandom_range(0, 299);
            // Cleared bytes stay off the 8-aligned end-nibble addresses.
            if (pick < 6) begin
                send_request(OP_LOAD_GFX, 15'($urandom_range(GFX_LO, GFX_HI)) | 15'd1,
                             8'h00);
            end
            if (pick < 9) begin
                pick = $urandom_range(GFX_LO, GFX_HI);
                send_request(OP_LOAD_GFX, 15'(pick), gfx_byte(15'(pick)));
            end
            else if (pick < 12)
                random_sprite($urandom_range(3, SPRITE_COUNT - 1));
            else if (pick == 12)
                send_request(OP_START, 15'($urandom), 8'($urandom));
            else
                send_request(OP_STEP, 15'($urandom), 8'($urandom));
            await_results();
            steps++;
        end
    endtask

    initial
    begin
        int frame;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_STEP;
        in_ch.address = '0;
        in_ch.data = '0;
        items = 0;
        quiet = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A step with no frame armed only reports the engine idle.
        send_request(OP_STEP, 15'h7FFF, 8'hFF);
        // Bytes around address zero for the pointer and offset wrap sprites.
        send_request(OP_LOAD_GFX, 15'h0000, 8'h12);
        send_request(OP_LOAD_GFX, 15'h7FFF, 8'h34);
        send_request(OP_LOAD_GFX, 15'h7FFE, 8'hF5);
        send_request(OP_LOAD_GFX, 15'h0001, 8'h6F);
        send_request(OP_LOAD_GFX, 15'h0004, 8'hF0);
        for (int a = GFX_LO; a <= GFX_HI; a++)
            send_request(OP_LOAD_GFX, 15'(a), gfx_byte(15'(a)));
        // A row with no end nibble that stops at the byte limit.
        for (int a = 0; a < MAX_ROW_BYTES; a++)
            send_request(OP_LOAD_GFX, RUN_BASE + 15'(a),
                         {4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))});
        // Forward row that starts near the top of the graphics ROM.
        load_sprite(0, 8'd10, 8'd11, 8'd40, 16'h0004, 16'h7FFC);
        // Row offset that wraps past 16 bits, two rows.
        load_sprite(1, 8'd20, 8'd22, 8'd0, 16'h0003, 16'hFFFE);
        load_sprite(2, 8'd30, 8'd31, 8'd8, 16'h0000, {1'b0, RUN_BASE});
        for (int s = 3; s < SPRITE_COUNT; s++)
            random_sprite(s);
        load_sprite(3, 8'd5, 8'd7, 8'hFF, 16'h0000, 16'h0130);
        load_sprite(4, 8'd50, 8'd50, 8'd9, 16'h0000, 16'h0130);
        load_sprite(5, 8'd60, 8'd52, 8'd9, 16'h0000, 16'h0130);

        frame = 0;
        while (items < ITEM_TARGET) begin
            case (frame)
                0:       ;
                1:       write_config(1'b1, 1'b1, 8'd0, 8'd255, 8'd0, 8'd255);
                2:       write_config(1'b0, 1'b1, 8'd255, 8'd0, 8'd255, 8'd0);
                3:       write_config(1'b1, 1'b0, 8'd8, 8'd247, 8'd16, 8'd223);
                default: write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 60)), 8'($urandom_range(180, 255)),
                                      8'($urandom_range(0, 60)), 8'($urandom_range(150, 255)));
            endcase
            run_frame();
            if ($urandom_range(0, 1))
                send_request(OP_STEP, 15'($urandom), 8'($urandom));
            for (int k = $urandom_range(2, 8); k > 0; k--)
                random_sprite($urandom_range(3, SPRITE_COUNT - 1));
            for (int k = $urandom_range(2, 10); k > 0; k--) begin
                frame = frame;
                send_request(OP_LOAD_GFX, 15'($urandom_range(GFX_LO, GFX_HI)) | 15'd1,
                             8'h00);
            end
            for (int a = GFX_LO; a <= GFX_HI; a += 8)
                if ($urandom_range(0, 3) == 0)
                    send_request(OP_LOAD_GFX, 15'(a), gfx_byte(15'(a)));
            frame++;
        end

        await_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pnsr_pkg.sv
hw/rtl/pnsr_if.sv
hw/rtl/pnsr_datapath.sv
hw/rtl/pnsr_ctrl.sv
hw/rtl/packed_nibble_sprite_renderer.sv
verif/pnsr_render_checker.sv
verif/tb.sv
